// File: hw/rtl/olsbs_pkg.sv
// Shared types and codes for the ordered list store with two-ended search.
`timescale 1ns / 1ps

package olsbs_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_HEAD,
    FSM_TAIL,
    FSM_SHIFT
  } fsm_t;

endpackage

// File: hw/rtl/ordered_list_store_bidir_search_unit.sv
// Top level: bounded ordered list with append, two-ended search, modify and delete.
`timescale 1ns / 1ps

// A command is one transfer on the slave side and gives one result transfer on the
// master side. The entries live in a single memory with one write port and one
// registered read port, and every walk over the list goes through that read port
// one entry per cycle. Append, whether it stores the value or finds the list full,
// and any other command on an empty list, finishes from the idle state with no walk.
// Modify and a missed search or delete walk from the head to the first match (the
// whole list on a miss). A search walks from the head to the first match and then
// from the tail down to the last match, and a delete walks the whole list, as it
// moves every later entry down one place. A new command is taken only when the
// block is idle and the previous result has been transferred.
module ordered_list_store_bidir_search_unit
  import olsbs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // action [1:0], key_value [33:2], replacement [65:34], zero padding above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status [1:0], pos_from_head [5:2], pos_from_tail [9:6], head_is_nearer [10],
  // entry_count [15:11]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fsm_t state, state_next;

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [CW-1:0]      occ, occ_next;
  logic [CW-1:0]      ptr, ptr_next;
  logic [IW-1:0]      head_pos;
  action_t            action_q;
  logic [VALUE_W-1:0] key_q, repl_q;

  logic [VALUE_W-1:0] rd_q;
  logic [IW-1:0]      rd_idx;
  logic               rd_vld;
  logic               issue;

  logic               we;
  logic [IW-1:0]      wa;
  logic [VALUE_W-1:0] wd;

  logic               fin;
  status_t            fin_status;
  logic [CW-1:0]      fin_ph, fin_pt;
  logic               fin_near;

  logic               accept;
  action_t            in_action;
  logic [VALUE_W-1:0] in_key, in_repl;
  logic               rd_hit;
  logic               save_head;
  logic [CW-1:0]      tail_dist;

  logic [CW+POS_W-1:0]   ph_ext, pt_ext;
  logic [CW+COUNT_W-1:0] cnt_ext;

  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_ph, out_pt;
  logic                out_near;
  logic [COUNT_W-1:0]  out_count;

  assign in_action = action_t'(s_tdata[ACTION_W-1:0]);
  assign in_key    = s_tdata[ACTION_W+VALUE_W-1:ACTION_W];
  assign in_repl   = s_tdata[ACTION_W+2*VALUE_W-1:ACTION_W+VALUE_W];

  assign s_tready = (state == FSM_IDLE) && !m_tvalid;
  assign accept   = s_tvalid && s_tready;
  assign rd_hit   = rd_vld && (rd_q == key_q);
  assign tail_dist = occ - CW'(1) - CW'(rd_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    occ_next   = occ;
    issue      = 1'b0;
    we         = 1'b0;
    wa         = rd_idx;
    wd         = rd_q;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_ph     = '0;
    fin_pt     = '0;
    fin_near   = 1'b0;
    save_head  = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          if (in_action == ACT_APPEND) begin
            fin = 1'b1;
            if (occ >= CW'(DEPTH)) begin
              fin_status = ST_FULL;
            end else begin
              we       = 1'b1;
              wa       = occ[IW-1:0];
              wd       = in_key;
              occ_next = occ + CW'(1);
            end
          end else if (occ == '0) begin
            fin        = 1'b1;
            fin_status = ST_EMPTY;
          end else begin
            ptr_next   = '0;
            state_next = FSM_HEAD;
          end
        end
      end
      FSM_HEAD: begin
        if (rd_hit) begin
          unique case (action_q)
            ACT_SEARCH: begin
              save_head  = 1'b1;
              ptr_next   = occ - CW'(1);
              state_next = FSM_TAIL;
            end
            ACT_MODIFY: begin
              we         = 1'b1;
              wd         = repl_q;
              fin        = 1'b1;
              state_next = FSM_IDLE;
            end
            ACT_DELETE: begin
              ptr_next   = CW'(rd_idx) + CW'(1);
              state_next = FSM_SHIFT;
            end
            default: begin
              fin        = 1'b1;
              state_next = FSM_IDLE;
            end
          endcase
        end else if (rd_vld && (CW'(rd_idx) == occ - CW'(1))) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
          state_next = FSM_IDLE;
        end else begin
          issue    = (ptr < occ);
          ptr_next = issue ? ptr + CW'(1) : ptr;
        end
      end
      FSM_TAIL: begin
        // A match is known to exist, so the downward walk always ends on one.
        if (rd_hit) begin
          fin        = 1'b1;
          fin_ph     = CW'(head_pos);
          fin_pt     = tail_dist;
          fin_near   = (CW'(head_pos) < tail_dist);
          state_next = FSM_IDLE;
        end else begin
          issue    = 1'b1;
          ptr_next = (ptr == '0) ? ptr : ptr - CW'(1);
        end
      end
      FSM_SHIFT: begin
        // Each entry read from the next place up is written one place down.
        if (rd_vld) begin
          we = 1'b1;
          wa = rd_idx - IW'(1);
        end
        if (ptr < occ) begin
          issue    = 1'b1;
          ptr_next = ptr + CW'(1);
        end else begin
          fin        = 1'b1;
          occ_next   = occ - CW'(1);
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q   <= mem[ptr[IW-1:0]];
    rd_idx <= ptr[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else begin
      occ    <= occ_next;
      ptr    <= ptr_next;
      rd_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q <= in_action;
      key_q    <= in_key;
      repl_q   <= in_repl;
    end
    if (save_head) begin
      head_pos <= rd_idx;
    end
  end

  assign ph_ext  = {{POS_W{1'b0}}, fin_ph};
  assign pt_ext  = {{POS_W{1'b0}}, fin_pt};
  assign cnt_ext = {{COUNT_W{1'b0}}, occ_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_status <= fin_status;
      out_ph     <= ph_ext[POS_W-1:0];
      out_pt     <= pt_ext[POS_W-1:0];
      out_near   <= fin_near;
      out_count  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign m_tdata = {out_count, out_near, out_pt, out_ph, out_status};

endmodule

// File: test/tb_ordered_list_store_bidir_search_unit.sv
// Self-checking testbench for the ordered list store with two-ended search.
`timescale 1ns / 1ps

module tb_ordered_list_store_bidir_search_unit;
  import olsbs_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  localparam int RANDOM_CMDS = 1350;

  typedef struct packed {
    status_t     status;
    logic [3:0]  ph;
    logic [3:0]  pt;
    logic        near;
    logic [4:0]  count;
  } list_result_t;

  typedef struct {
    action_t      act;
    logic [31:0]  key;
    logic [31:0]  repl;
    int           reps;
    bit           typed;
    status_t      st;
    logic [4:0]   count;
  } cmd_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Shadow copy of the list contents, updated when a command is accepted.
  logic [31:0]  list_vals [LIST_DEPTH];
  int           list_len = 0;
  list_result_t result_q [$];
  cmd_row_t     cmd_rows [$];
  int           mismatches = 0;
  int           results_seen = 0;

  ordered_list_store_bidir_search_unit #(.DEPTH(LIST_DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Applies one command to the shadow list and returns the result it should give.
  function automatic list_result_t apply_command(action_t act, logic [31:0] key,
                                                 logic [31:0] repl);
    list_result_t r;
    int first;
    int last;
    int i;
    r = '0;
    r.status = ST_OK;
    first = -1;
    last = -1;
    if (act == ACT_APPEND) begin
      if (list_len >= LIST_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        list_vals[list_len] = key;
        list_len++;
      end
    end else if (list_len == 0) begin
      r.status = ST_EMPTY;
    end else begin
      for (i = 0; i < list_len; i++)
        if (first < 0 && list_vals[i] == key) first = i;
      if (first < 0) begin
        r.status = ST_NOT_FOUND;
      end else if (act == ACT_SEARCH) begin
        for (i = list_len - 1; i >= 0; i--)
          if (last < 0 && list_vals[i] == key) last = i;
        r.ph = first[3:0];
        r.pt = 4'(list_len - 1 - last);
        r.near = (first < list_len - 1 - last);
      end else if (act == ACT_MODIFY) begin
        list_vals[first] = repl;
      end else begin
        for (i = first; i + 1 < list_len; i++)
          list_vals[i] = list_vals[i + 1];
        list_len--;
      end
    end
    r.count = list_len[4:0];
    return r;
  endfunction

  task automatic add_row(action_t act, logic [31:0] key, logic [31:0] repl, int reps,
                         bit typed, status_t st, logic [4:0] count);
    cmd_row_t row;
    row.act = act;
    row.key = key;
    row.repl = repl;
    row.reps = reps;
    row.typed = typed;
    row.st = st;
    row.count = count;
    cmd_rows.push_back(row);
  endtask

  // Offers one command after an optional gap, and records its expected result on
  // acceptance. With drain set it first waits until every result has come back.
  task automatic send_cmd(action_t act, logic [31:0] key, logic [31:0] repl, int gap,
                          bit drain, bit typed, list_result_t want);
    list_result_t pred;
    if (drain || gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (result_q.size() != 0);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, repl, key, act};
    do @(posedge clk); while (!s_tready);
    pred = apply_command(act, key, repl);
    result_q.push_back(typed ? want : pred);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] pool [8];
    int r;
    pool = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
             32'h1, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_FFFF};
    r = $urandom_range(0, 9);
    if (r < 4 && list_len > 0) return list_vals[$urandom_range(0, list_len - 1)];
    if (r < 8) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Command source: directed rows first, then random traffic.
  initial begin
    list_result_t want;
    action_t act;
    bit growing;
    int gap;
    int r;
    int n;
    int k;
    growing = 1'b1;
    add_row(ACT_SEARCH, 32'h0,         32'h0,         1, 1, ST_EMPTY,     5'd0);
    add_row(ACT_MODIFY, 32'h0,         32'hFFFF_FFFF, 1, 1, ST_EMPTY,     5'd0);
    add_row(ACT_DELETE, 32'hFFFF_FFFF, 32'h0,         1, 1, ST_EMPTY,     5'd0);
    add_row(ACT_APPEND, 32'h8000_0000, 32'h0,         1, 1, ST_OK,        5'd1);
    // Removing the sole entry must leave the list empty.
    add_row(ACT_DELETE, 32'h8000_0000, 32'h0,         1, 1, ST_OK,        5'd0);
    add_row(ACT_APPEND, 32'h7FFF_FFFF, 32'h0,         1, 1, ST_OK,        5'd1);
    add_row(ACT_APPEND, 32'h8000_0000, 32'h0,         1, 1, ST_OK,        5'd2);
    add_row(ACT_APPEND, 32'hFFFF_FFFF, 32'h0,         1, 1, ST_OK,        5'd3);
    add_row(ACT_APPEND, 32'h0,         32'h0,         1, 1, ST_OK,        5'd4);
    add_row(ACT_APPEND, 32'h7FFF_FFFF, 32'h0,         1, 1, ST_OK,        5'd5);
    add_row(ACT_SEARCH, 32'h7FFF_FFFF, 32'h0,         1, 0, ST_OK,        5'd0);
    add_row(ACT_SEARCH, 32'h8000_0000, 32'h0,         1, 0, ST_OK,        5'd0);
    add_row(ACT_SEARCH, 32'h1234_5678, 32'h0,         1, 1, ST_NOT_FOUND, 5'd5);
    add_row(ACT_MODIFY, 32'hFFFF_FFFF, 32'h5555_5555, 1, 0, ST_OK,        5'd0);
    add_row(ACT_MODIFY, 32'h1234_5678, 32'h0,         1, 1, ST_NOT_FOUND, 5'd5);
    add_row(ACT_DELETE, 32'h1234_5678, 32'h0,         1, 1, ST_NOT_FOUND, 5'd5);
    add_row(ACT_DELETE, 32'h7FFF_FFFF, 32'h0,         1, 0, ST_OK,        5'd0);
    add_row(ACT_APPEND, 32'hAAAA_AAAA, 32'h0,        11, 0, ST_OK,        5'd0);
    add_row(ACT_APPEND, 32'h0000_FFFF, 32'h0,         1, 1, ST_OK,        5'd16);
    add_row(ACT_APPEND, 32'h1,         32'h0,         1, 1, ST_FULL,      5'd16);
    add_row(ACT_SEARCH, 32'h0000_FFFF, 32'h0,         1, 0, ST_OK,        5'd0);
    add_row(ACT_SEARCH, 32'h8000_0000, 32'h0,         1, 0, ST_OK,        5'd0);
    add_row(ACT_MODIFY, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, ST_OK,        5'd0);
    add_row(ACT_MODIFY, 32'h0,         32'h8000_0000, 1, 0, ST_OK,        5'd0);
    add_row(ACT_DELETE, 32'h0000_FFFF, 32'h0,         1, 0, ST_OK,        5'd0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (cmd_rows[i]) begin
      want = '0;
      want.status = cmd_rows[i].st;
      want.count = cmd_rows[i].count;
      for (k = 0; k < cmd_rows[i].reps; k++)
        send_cmd(cmd_rows[i].act, cmd_rows[i].key, cmd_rows[i].repl,
                 $urandom_range(0, 16), 1'b0, cmd_rows[i].typed, want);
    end

    for (n = 0; n < RANDOM_CMDS; n++) begin
      // Swing the list between empty and full so that every depth is exercised.
      if (list_len == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (list_len == 0) growing = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 25) act = ACT_SEARCH;
      else if (r < 40) act = ACT_MODIFY;
      else if (r < 70) act = growing ? ACT_APPEND : ACT_DELETE;
      else if (r < 85) act = ACT_APPEND;
      else act = ACT_DELETE;
      gap = ((n / 64) % 3 == 0) ? 0 : $urandom_range(0, 16);
      send_cmd(act, pick_value(), ($urandom_range(0, 1) != 0) ? pick_value() : $urandom,
               gap, (n == 600 || n == 1000), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result sink with random back-pressure and one long hold-off.
  initial begin
    list_result_t got;
    list_result_t exp_r;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (results_seen == 300) stall = 250;
      else if ((results_seen / 80) % 3 == 1) stall = 0;
      else stall = $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
      got.status = status_t'(m_tdata[1:0]);
      got.ph     = m_tdata[5:2];
      got.pt     = m_tdata[9:6];
      got.near   = m_tdata[10];
      got.count  = m_tdata[15:11];
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transfer: %h", m_tdata);
      end else begin
        exp_r = result_q.pop_front();
        if (got.status !== exp_r.status || got.ph !== exp_r.ph || got.pt !== exp_r.pt ||
            got.near !== exp_r.near || got.count !== exp_r.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: expected st=%0d ph=%0d pt=%0d near=%0d cnt=%0d, %s",
                     results_seen, exp_r.status, exp_r.ph, exp_r.pt, exp_r.near,
                     exp_r.count, $sformatf("got st=%0d ph=%0d pt=%0d near=%0d cnt=%0d",
                     got.status, got.ph, got.pt, got.near, got.count));
        end
      end
    end
  end

endmodule
